// ===== rtl/trrfm_pkg.sv =====
// Shared types and constants for the thermal rate-of-rise fault monitor.
// No dependencies; imported by the monitor top level.
`timescale 1ns / 1ps
`default_nettype none

package trrfm_pkg;

  typedef logic [1:0] fault_code_t;

  localparam fault_code_t FAULT_NONE      = 2'd0;
  localparam fault_code_t FAULT_DRUM_OPEN = 2'd1;
  localparam fault_code_t FAULT_HEAT_OPEN = 2'd2;
  localparam fault_code_t FAULT_CUTOFF    = 2'd3;

  // request kinds on the input channel
  localparam logic ACT_SAMPLE = 1'b0;
  localparam logic ACT_RESET  = 1'b1;

  // configuration register indexes
  localparam logic CFG_CUTOFF   = 1'b0;
  localparam logic CFG_MIN_SPAN = 1'b1;

  localparam logic [11:0] CUTOFF_RESET   = 12'd1040;
  localparam logic [15:0] MIN_SPAN_RESET = 16'd1000;

  // quarter degrees per ms -> 0.01 C per minute: 25 * 60000
  localparam logic [20:0] RATE_SCALE = 21'd1500000;

  // dividend is 33 bits wide: one quotient bit per step
  localparam int          QUO_W     = 33;
  localparam logic [5:0]  DIV_STEPS = 6'd33;

  localparam logic [QUO_W-1:0] RATE_POS_LIMIT = 33'd8388607;
  localparam logic [QUO_W-1:0] RATE_NEG_LIMIT = 33'd8388608;
  localparam logic signed [23:0] RATE_MAX = 24'sh7FFFFF;
  localparam logic signed [23:0] RATE_MIN = 24'sh800000;

endpackage

`default_nettype wire

// ===== rtl/trrfm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module trrfm_ram #(
  parameter int WIDTH = 44,
  parameter int DEPTH = 30
) (
  input  wire logic                             clk,
  input  wire logic                             we,
  input  wire logic [$clog2(DEPTH)-1:0]         waddr,
  input  wire logic [WIDTH-1:0]                 wdata,
  input  wire logic [$clog2(DEPTH)-1:0]         raddr,
  output      logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/thermal_rate_of_rise_fault_monitor.sv =====
// Thermal rate-of-rise and probe fault monitor, top level.
// Depends on trrfm_pkg (codes, constants) and trrfm_ram (sample ring).
//
//  channel   signals                                         dir  notes
//  --------  ----------------------------------------------  ---  ----------------------
//  in        in_valid/in_ready, action, time_ms, drum_temp,   in   sample or fault reset
//            drum_open, heater_temp, heater_open
//  out       out_valid/out_ready, rise_rate, fault_latched,   out  one result per request
//            fault_code, reset_refused
//  cfg       cfg_valid/cfg_ready, cfg_index, cfg_data         in   0 cutoff, 1 min span
//
// Slope path: a sample with a valid drum reading and two or more ring entries
//   goes from accept to result through ring read, one multiply, 33 steps
//   of the shared restoring subtractor, saturation and output load. If the
//   span is zero or under the minimum the slope ends after the ring read.
//   Other requests go straight to the output load.
// in_ready is high only while the sequencer is idle; one request in flight.
// The output register holds a finished result while the next request is
//   accepted; a request whose result finds the register full waits in FINISH.
// Reset (rst, synchronous) clears the fault latch, ring pointers, held rate,
//   last-reading valid flags and loads default configuration. No clear pass.
// cfg_ready is always high; writes are expected only while idle.
`timescale 1ns / 1ps
`default_nettype none

module thermal_rate_of_rise_fault_monitor
  import trrfm_pkg::*;
#(
  parameter int WINDOW = 30
) (
  input  wire logic               clk,
  input  wire logic               rst,
  // sample / reset requests
  input  wire logic               in_valid,
  output      logic               in_ready,
  input  wire logic               action,
  input  wire logic [31:0]        time_ms,
  input  wire logic [11:0]        drum_temp,
  input  wire logic               drum_open,
  input  wire logic [11:0]        heater_temp,
  input  wire logic               heater_open,
  // results
  output      logic               out_valid,
  input  wire logic               out_ready,
  output      logic signed [23:0] rise_rate,
  output      logic               fault_latched,
  output      logic [1:0]         fault_code,
  output      logic               reset_refused,
  // configuration
  input  wire logic               cfg_valid,
  output      logic               cfg_ready,
  input  wire logic               cfg_index,
  input  wire logic [15:0]        cfg_data
);

  localparam int AW = $clog2(WINDOW);      // ring index width
  localparam int FW = $clog2(WINDOW + 1);  // fill count must hold WINDOW
  localparam int RW = 32 + 12;             // ring entry: time, reading

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_READ   = 3'd1;
  localparam logic [2:0] ST_MUL    = 3'd2;
  localparam logic [2:0] ST_DIV    = 3'd3;
  localparam logic [2:0] ST_SAT    = 3'd4;
  localparam logic [2:0] ST_FINISH = 3'd5;

  logic [2:0]        state;

  // configuration registers
  logic [11:0]       cutoff;
  logic [15:0]       min_span;

  // ring control
  logic [AW-1:0]     head;
  logic [FW-1:0]     fill;

  // fault latch and last readings
  logic              fault_flag;
  fault_code_t       fault_kind;
  logic [11:0]       last_drum;
  logic [11:0]       last_heater;
  logic              last_drum_ok;
  logic              last_heater_ok;
  logic              refused;

  logic signed [23:0] rate_hold;

  // newest sample kept for the slope
  logic [31:0]       cur_time;
  logic [11:0]       cur_drum;

  // slope datapath
  logic              diff_neg;
  logic [11:0]       diff_mag;
  logic [31:0]       den;
  logic [QUO_W-1:0]  num;       // dividend, then quotient shifted in
  logic [31:0]       rem;
  logic [5:0]        step;

  // ring RAM
  logic              ram_we;
  logic [AW-1:0]     ram_raddr;
  logic [RW-1:0]     ram_rdata;

  logic              in_fire;
  logic              push;
  logic              hot_last;
  logic              hot_now;
  logic [AW-1:0]     head_inc;
  logic [31:0]       span;
  logic [12:0]       diff;
  logic [32:0]       rem_sh;
  logic [33:0]       rem_sub;
  logic              out_free;
  logic              out_load;
  logic signed [23:0] rate_sat;

  assign in_ready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;
  assign push      = in_fire && (action == ACT_SAMPLE) && !drum_open;
  assign out_free  = !out_valid || out_ready;
  assign out_load  = (state == ST_FINISH) && out_free;

  assign head_inc = (head == AW'(WINDOW - 1)) ? '0 : head + 1'b1;

  // oldest entry after this push: slot 0 until the ring is full, then the
  // slot just past the one being overwritten
  assign ram_raddr = (fill == FW'(WINDOW)) ? head_inc : '0;
  assign ram_we    = push;

  trrfm_ram #(
    .WIDTH (RW),
    .DEPTH (WINDOW)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (head),
    .wdata ({time_ms, drum_temp}),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign hot_last = (last_drum_ok && (last_drum > cutoff)) ||
                    (last_heater_ok && (last_heater > cutoff));
  assign hot_now  = (drum_temp > cutoff) || (heater_temp > cutoff);

  // newest minus oldest, time wraps mod 2^32
  assign span = cur_time - ram_rdata[RW-1:12];
  assign diff = {1'b0, cur_drum} - {1'b0, ram_rdata[11:0]};

  // one restoring-division step
  assign rem_sh  = {rem, num[QUO_W-1]};
  assign rem_sub = {1'b0, rem_sh} - {2'b00, den};

  always_comb begin
    if (diff_neg) begin
      rate_sat = (num > RATE_NEG_LIMIT) ? RATE_MIN : -$signed(num[23:0]);
    end else begin
      rate_sat = (num > RATE_POS_LIMIT) ? RATE_MAX : $signed(num[23:0]);
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cutoff   <= CUTOFF_RESET;
      min_span <= MIN_SPAN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_CUTOFF:   cutoff   <= cfg_data[11:0];
        CFG_MIN_SPAN: min_span <= cfg_data;
        default:      ;
      endcase
    end
  end

  // sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      head           <= '0;
      fill           <= '0;
      rate_hold      <= '0;
      fault_flag     <= 1'b0;
      fault_kind     <= FAULT_NONE;
      last_drum_ok   <= 1'b0;
      last_heater_ok <= 1'b0;
      refused        <= 1'b0;
      step           <= '0;
      out_valid      <= 1'b0;
    end else begin
      // a new result may replace the one leaving in the same cycle
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_fire) begin
            if (action == ACT_RESET) begin
              state   <= ST_FINISH;
              refused <= hot_last;
              if (!hot_last) begin
                fault_flag <= 1'b0;
                fault_kind <= FAULT_NONE;
              end
            end else begin
              refused <= 1'b0;
              if (drum_open) begin
                fault_flag <= 1'b1;
                fault_kind <= FAULT_DRUM_OPEN;
              end else if (heater_open) begin
                fault_flag <= 1'b1;
                fault_kind <= FAULT_HEAT_OPEN;
              end else if (hot_now) begin
                fault_flag <= 1'b1;
                fault_kind <= FAULT_CUTOFF;
              end
              last_drum_ok   <= !drum_open;
              last_heater_ok <= !heater_open;
              if (!drum_open) begin
                head <= head_inc;
                if (fill != FW'(WINDOW)) begin
                  fill <= fill + 1'b1;
                end
                // first entry: no slope yet
                if (fill == '0) begin
                  rate_hold <= '0;
                  state     <= ST_FINISH;
                end else begin
                  state <= ST_READ;
                end
              end else begin
                state <= ST_FINISH;
              end
            end
          end
        end
        ST_READ: begin
          if ((span < {16'd0, min_span}) || (span == '0)) begin
            rate_hold <= '0;
            state     <= ST_FINISH;
          end else begin
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          step  <= '0;
          state <= ST_DIV;
        end
        ST_DIV: begin
          step <= step + 1'b1;
          if (step == DIV_STEPS - 1'b1) begin
            state <= ST_SAT;
          end
        end
        ST_SAT: begin
          rate_hold <= rate_sat;
          state     <= ST_FINISH;
        end
        ST_FINISH: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire && (action == ACT_SAMPLE)) begin
      last_drum   <= drum_temp;
      last_heater <= heater_temp;
    end
    if (push) begin
      cur_time <= time_ms;
      cur_drum <= drum_temp;
    end
    if (state == ST_READ) begin
      den      <= span;
      diff_neg <= diff[12];
      diff_mag <= diff[12] ? 12'(-diff) : diff[11:0];
    end
    if (state == ST_MUL) begin
      num <= QUO_W'(diff_mag) * QUO_W'(RATE_SCALE);
      rem <= '0;
    end
    if (state == ST_DIV) begin
      if (!rem_sub[33]) begin
        rem <= rem_sub[31:0];
        num <= {num[QUO_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh[31:0];
        num <= {num[QUO_W-2:0], 1'b0};
      end
    end
    if (out_load) begin
      rise_rate     <= rate_hold;
      fault_latched <= fault_flag;
      fault_code    <= fault_kind;
      reset_refused <= refused;
    end
  end

  // checks
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FW'(WINDOW))
    else $error("ring fill count beyond window");

  a_head_bound: assert property (@(posedge clk) disable iff (rst)
    head <= AW'(WINDOW - 1))
    else $error("ring head beyond window");

  a_flag_code: assert property (@(posedge clk) disable iff (rst)
    fault_flag == (fault_kind != FAULT_NONE))
    else $error("fault flag and fault code disagree");

  a_rate_hold: assert property (@(posedge clk) disable iff (rst)
    (state != ST_SAT && state != ST_READ && !push) |=> $stable(rate_hold))
    else $error("held rate changed outside slope update");

  a_div_steps: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (step < DIV_STEPS))
    else $error("divider step count overran");

endmodule

`default_nettype wire
